// ===== rtl/core/m3h64_pkg.sv =====
// ============================================================================
// m3h64_pkg: shared types and constants for the single-lane Murmur3 hash
// Mix and finalizer constants, multiplier operand selects, and the
// command bundle from controller to datapath.
// ============================================================================
package m3h64_pkg;

    localparam logic [63:0] MIX_C1   = 64'h87c3_7b91_1142_53d5;
    localparam logic [63:0] MIX_C2   = 64'h4cf5_ad43_2745_937f;
    localparam logic [63:0] FOLD_ADD = 64'h0000_0000_52dc_e729;
    localparam logic [63:0] FIN_M1   = 64'hff51_afd7_ed55_8ccd;
    localparam logic [63:0] FIN_M2   = 64'hc4ce_b9fe_1a85_ec53;

    localparam int unsigned ROT_MIX  = 31;
    localparam int unsigned ROT_FOLD = 27;
    localparam int unsigned FIN_SHR  = 33;

    localparam logic [3:0] FULL_COUNT = 4'd8;

    // multiplier constant operand
    typedef enum logic [1:0] {
        MSEL_C1,
        MSEL_C2,
        MSEL_M1,
        MSEL_M2
    } t_mul_sel;

    // what the product-sum stage does with the finished product
    typedef enum logic [1:0] {
        SUM_SCR1,
        SUM_SCR2,
        SUM_FIN1,
        SUM_FIN2
    } t_sum_op;

    typedef struct packed {
        logic     load;     // latch accepted transaction
        logic     pp_en;    // register partial products
        t_mul_sel mul_sel;
        logic     sum_en;   // act on the summed product
        t_sum_op  sum_op;
    } t_dp_cmd;

    function automatic logic [63:0] mul_const(input t_mul_sel sel);
        logic [63:0] c;
        unique case (sel)
            MSEL_C1: c = MIX_C1;
            MSEL_C2: c = MIX_C2;
            MSEL_M1: c = FIN_M1;
            MSEL_M2: c = FIN_M2;
            default: c = MIX_C1;
        endcase
        return c;
    endfunction

    // counts above eight act as a full block
    function automatic logic [3:0] sat_count(input logic [3:0] cnt);
        return (cnt > FULL_COUNT) ? FULL_COUNT : cnt;
    endfunction

    function automatic logic [63:0] byte_mask(input logic [3:0] cnt);
        logic [63:0] m;
        for (int i = 0; i < 8; i++) begin
            m[8*i +: 8] = ({1'b0, cnt} > 5'(i)) ? 8'hff : 8'h00;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/m3h64_ctrl.sv =====
// ============================================================================
// m3h64_ctrl: sequencer for the single-lane Murmur3 hash
// Walks the shared two-stage multiplier through the four multiplies of one
// transaction and owns the input and output handshakes.
// ============================================================================
module m3h64_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output m3h64_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCR1_PP,
        ST_SCR1_SUM,
        ST_SCR2_PP,
        ST_SCR2_SUM,
        ST_FIN1_PP,
        ST_FIN1_SUM,
        ST_FIN2_PP,
        ST_FIN2_SUM
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_out_free;

    assign w_accept   = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '{load: 1'b0, pp_en: 1'b0, mul_sel: m3h64_pkg::MSEL_C1,
                        sum_en: 1'b0, sum_op: m3h64_pkg::SUM_SCR1};
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.load = w_accept;
                if (w_accept) begin
                    n_state = ST_SCR1_PP;
                end
            end
            ST_SCR1_PP: begin
                o_cmd.pp_en   = 1'b1;
                o_cmd.mul_sel = m3h64_pkg::MSEL_C1;
                n_state       = ST_SCR1_SUM;
            end
            ST_SCR1_SUM: begin
                o_cmd.sum_en = 1'b1;
                o_cmd.sum_op = m3h64_pkg::SUM_SCR1;
                n_state      = ST_SCR2_PP;
            end
            ST_SCR2_PP: begin
                o_cmd.pp_en   = 1'b1;
                o_cmd.mul_sel = m3h64_pkg::MSEL_C2;
                n_state       = ST_SCR2_SUM;
            end
            ST_SCR2_SUM: begin
                o_cmd.sum_en = 1'b1;
                o_cmd.sum_op = m3h64_pkg::SUM_SCR2;
                n_state      = ST_FIN1_PP;
            end
            ST_FIN1_PP: begin
                o_cmd.pp_en   = 1'b1;
                o_cmd.mul_sel = m3h64_pkg::MSEL_M1;
                n_state       = ST_FIN1_SUM;
            end
            ST_FIN1_SUM: begin
                o_cmd.sum_en = 1'b1;
                o_cmd.sum_op = m3h64_pkg::SUM_FIN1;
                n_state      = ST_FIN2_PP;
            end
            ST_FIN2_PP: begin
                o_cmd.pp_en   = 1'b1;
                o_cmd.mul_sel = m3h64_pkg::MSEL_M2;
                n_state       = ST_FIN2_SUM;
            end
            ST_FIN2_SUM: begin
                // hold here until the output register can take the digest
                o_cmd.sum_op = m3h64_pkg::SUM_FIN2;
                if (w_out_free) begin
                    o_cmd.sum_en = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_SCR1_PP))
        else $error("accepted transaction did not start the multiply sequence");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN2_SUM && r_out_valid && !i_out_ready)
        |=> (r_state == ST_FIN2_SUM))
        else $error("digest overwrote an untaken result");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FIN2_SUM))
        else $error("output valid raised outside the final sum step");
`endif

endmodule

// ===== rtl/core/m3h64_dp.sv =====
// ============================================================================
// m3h64_dp: datapath for the single-lane Murmur3 hash
// Seed, running hash and length registers, one shared 64x64 low-half
// multiplier split into 32x32 partial products, and the digest register.
// ============================================================================
module m3h64_dp (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  m3h64_pkg::t_dp_cmd i_cmd,
    input  logic               i_cfg_we,
    input  logic [63:0]        i_cfg_wdata,
    input  logic [63:0]        i_data_bytes,
    input  logic [3:0]         i_byte_count,
    input  logic               i_restart,
    output logic [63:0]        o_digest
);

    logic [63:0] r_seed;
    logic [63:0] r_hash;
    logic [63:0] r_len;
    logic        r_full;
    logic [63:0] r_op;
    logic [63:0] r_pp_ll;
    logic [31:0] r_pp_lh;
    logic [31:0] r_pp_hl;
    logic [63:0] r_digest;

    logic [3:0]  w_cnt;
    logic [63:0] w_base_len;
    logic [63:0] w_const;
    logic [63:0] w_pp_ll;
    logic [31:0] w_pp_lh;
    logic [31:0] w_pp_hl;
    logic [63:0] w_prod;
    logic [63:0] w_prod_fin;
    logic [63:0] w_mixed;
    logic [63:0] w_rot;
    logic [63:0] w_folded;
    logic [63:0] w_new_hash;
    logic [63:0] w_pre_fin;

    assign w_cnt      = m3h64_pkg::sat_count(i_byte_count);
    assign w_base_len = i_restart ? 64'd0 : r_len;

    // partial products of the low 64 bits of op * const
    assign w_const = m3h64_pkg::mul_const(i_cmd.mul_sel);
    assign w_pp_ll = {32'd0, r_op[31:0]} * {32'd0, w_const[31:0]};
    assign w_pp_lh = r_op[31:0] * w_const[63:32];
    assign w_pp_hl = r_op[63:32] * w_const[31:0];
    assign w_prod  = r_pp_ll + {r_pp_lh + r_pp_hl, 32'd0};

    assign w_prod_fin = w_prod ^ (w_prod >> m3h64_pkg::FIN_SHR);

    // fold: xor in scrambled block, then for a full block rotate, x5, add
    assign w_mixed    = r_hash ^ w_prod;
    assign w_rot      = {w_mixed[63-m3h64_pkg::ROT_FOLD:0],
                         w_mixed[63:64-m3h64_pkg::ROT_FOLD]};
    assign w_folded   = w_rot + {w_rot[61:0], 2'b00} + m3h64_pkg::FOLD_ADD;
    assign w_new_hash = r_full ? w_folded : w_mixed;
    assign w_pre_fin  = w_new_hash ^ r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'd0;
            r_hash <= 64'd0;
            r_len  <= 64'd0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
            if (i_cmd.load) begin
                if (i_restart) begin
                    r_hash <= r_seed;
                end
                r_len <= w_base_len + {60'd0, w_cnt};
            end else if (i_cmd.sum_en && i_cmd.sum_op == m3h64_pkg::SUM_SCR2) begin
                r_hash <= w_new_hash;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_data_bytes & m3h64_pkg::byte_mask(w_cnt);
            r_full <= (w_cnt == m3h64_pkg::FULL_COUNT);
        end else if (i_cmd.sum_en) begin
            case (i_cmd.sum_op)
                m3h64_pkg::SUM_SCR1: begin
                    r_op <= {w_prod[63-m3h64_pkg::ROT_MIX:0],
                             w_prod[63:64-m3h64_pkg::ROT_MIX]};
                end
                m3h64_pkg::SUM_SCR2: begin
                    r_op <= w_pre_fin ^ (w_pre_fin >> m3h64_pkg::FIN_SHR);
                end
                m3h64_pkg::SUM_FIN1: begin
                    r_op <= w_prod_fin;
                end
                default: begin
                    r_digest <= w_prod_fin;
                end
            endcase
        end
        if (i_cmd.pp_en) begin
            r_pp_ll <= w_pp_ll;
            r_pp_lh <= w_pp_lh;
            r_pp_hl <= w_pp_hl;
        end
    end

    assign o_digest = r_digest;

endmodule

// ===== rtl/core/murmur3_single_lane_hash64.sv =====
// Sequence: after the accepting edge the states SCR1_PP, SCR1_SUM, SCR2_PP,
//   SCR2_SUM, FIN1_PP, FIN1_SUM, FIN2_PP and FIN2_SUM follow; o_out_valid rises
//   as FIN2_SUM ends, which waits while the output register is full. One transaction
//   is in flight at a time, as the single shared 64-bit multiplier is used four times in series.
// Reset (synchronous, i_rst_n low): seed, running hash and length clear to
//   zero, sequencer returns to idle, no result pending.
// ============================================================================
// murmur3_single_lane_hash64: single-lane 64-bit Murmur3-style stream hash
// Absorbs up to eight bytes per transaction and returns the fmix64 digest of
// the running state after every transaction.
// ============================================================================
module murmur3_single_lane_hash64 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register write
    input  logic        i_cfg_we,
    input  logic [63:0] i_cfg_wdata,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_data_bytes,
    input  logic [3:0]  i_byte_count,
    input  logic        i_restart,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest
);

    // Per transaction the sequencer runs:
    //   accept  : mask bytes beyond the count, latch full-block flag,
    //             apply restart (hash <= seed, length <= 0), add count to
    //             length
    //   mul C1  -> rotate left 31
    //   mul C2  -> xor into hash; full block also rotates 27, x5, +const;
    //              then start fmix64 on (hash ^ length)
    //   mul M1  -> xor-shift 33
    //   mul M2  -> xor-shift 33, load digest register
    // A count of zero masks the data to zero, whose scramble is zero, so
    // the hash stays put. Each multiply registers three 32x32 partials in
    // its PP state and sums them in its SUM state.
    // The output register decouples the sides: a new transaction is taken
    // while a digest waits; the last step stalls only if it is still full.

    m3h64_pkg::t_dp_cmd w_cmd;

    m3h64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    m3h64_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_data_bytes (i_data_bytes),
        .i_byte_count (i_byte_count),
        .i_restart    (i_restart),
        .o_digest     (o_digest)
    );

endmodule
